>>> rtl/cursor_sequence_list_top_defines.svh
// Assertion macros shared by the cursor sequence list RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CURSOR_SEQUENCE_LIST_TOP_DEFINES_SVH
`define CURSOR_SEQUENCE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define CSL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define CSL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/csl_pkg.sv
// Package for the cursor sequence list: sizes, codes, word and control types.
// No dependencies.
package csl_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int IDX_W    = $clog2(CAPACITY + 1);

    // Null link: one past the last node.
    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_NO_CURRENT = 2'd1,
        ERR_FULL       = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FINISH,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic [DATA_W-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic              has_current;
        logic [DATA_W-1:0] current_value;
        logic [6:0]        item_count;
        logic [1:0]        error_code;
    } t_out_word;

    // Controller to datapath strobes, one per phase.
    typedef struct packed {
        logic accept;
        logic update;
        logic finish;
        logic load_out;
    } t_ctl;

    function automatic logic is_node(input logic [IDX_W-1:0] idx);
        return idx < IDX_W'(CAPACITY);
    endfunction

endpackage

>>> rtl/csl_ctrl.sv
// Sequencer for the cursor sequence list: phase state machine and output valid.
// Depends on csl_pkg.
module csl_ctrl
    import csl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_ctl o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_stall) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> rtl/csl_dpath.sv
// Datapath for the cursor sequence list: list pointers, link and data memories,
// output register. Depends on csl_pkg and the shared assertion macro header.
`include "cursor_sequence_list_top_defines.svh"

module csl_dpath
    import csl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    input  t_in_word  i_word,
    output t_out_word o_word
);

    // list state
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [IDX_W-1:0] r_cursor, n_cursor;
    logic [IDX_W-1:0] r_before, n_before;
    logic [IDX_W-1:0] r_free, n_free;
    logic [IDX_W-1:0] r_count, n_count;

    // memories
    logic [IDX_W-1:0]  r_link_mem [CAPACITY];
    logic [CAPACITY-1:0] r_link_vld;
    logic [DATA_W-1:0] r_data_mem [CAPACITY];

    // captured word and link reads
    logic [2:0]        r_cmd;
    logic [DATA_W-1:0] r_data;
    logic [IDX_W-1:0]  r_ra, r_rb;
    logic              r_ra_vld, r_rb_vld;
    logic [ADDR_W-1:0] r_ra_addr, r_rb_addr;
    logic              r_ra_node, r_rb_node;

    // deferred second link write
    logic              r_w2_en, n_w2_en;
    logic [ADDR_W-1:0] r_w2_addr, n_w2_addr;
    logic [IDX_W-1:0]  r_w2_data, n_w2_data;

    t_err              r_err, n_err;
    logic [DATA_W-1:0] r_rd_data;
    t_out_word         r_out;

    logic [IDX_W-1:0]  addr_b;
    logic [IDX_W-1:0]  next_free, next_b;
    logic              has, full;
    logic              w1_en;
    logic [ADDR_W-1:0] w1_addr;
    logic [IDX_W-1:0]  w1_data;
    logic              lw_en;
    logic [ADDR_W-1:0] lw_addr;
    logic [IDX_W-1:0]  lw_data;
    logic              d_we;

    // port B reads the node before the cursor for insert, the cursor otherwise
    assign addr_b = (i_word.command == CMD_INSERT) ? r_before : r_cursor;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd     <= i_word.command;
            r_data    <= i_word.data_in;
            r_ra      <= r_link_mem[r_free[ADDR_W-1:0]];
            r_rb      <= r_link_mem[addr_b[ADDR_W-1:0]];
            r_ra_vld  <= r_link_vld[r_free[ADDR_W-1:0]];
            r_rb_vld  <= r_link_vld[addr_b[ADDR_W-1:0]];
            r_ra_addr <= r_free[ADDR_W-1:0];
            r_rb_addr <= addr_b[ADDR_W-1:0];
            r_ra_node <= is_node(r_free);
            r_rb_node <= is_node(addr_b);
        end
        if (lw_en) begin
            r_link_mem[lw_addr] <= lw_data;
        end
    end

    // unwritten link entries read as the chained free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (lw_en) begin
            r_link_vld[lw_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_data_mem[r_free[ADDR_W-1:0]] <= r_data;
        end
        if (i_ctl.finish) begin
            r_rd_data <= r_data_mem[r_cursor[ADDR_W-1:0]];
        end
    end

    assign next_free = !r_ra_node ? NIL :
                       (r_ra_vld ? r_ra : IDX_W'(r_ra_addr) + IDX_W'(1));
    assign next_b    = !r_rb_node ? NIL :
                       (r_rb_vld ? r_rb : IDX_W'(r_rb_addr) + IDX_W'(1));

    assign has  = is_node(r_cursor);
    assign full = (r_count >= IDX_W'(CAPACITY)) || !is_node(r_free);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_cursor  = r_cursor;
        n_before  = r_before;
        n_free    = r_free;
        n_count   = r_count;
        n_err     = ERR_OK;
        w1_en     = 1'b0;
        w1_addr   = r_free[ADDR_W-1:0];
        w1_data   = NIL;
        n_w2_en   = 1'b0;
        n_w2_addr = r_before[ADDR_W-1:0];
        n_w2_data = r_free;
        d_we      = 1'b0;

        unique case (t_cmd'(r_cmd))
            CMD_START: begin
                n_cursor = r_head;
                n_before = NIL;
            end
            CMD_ADVANCE: begin
                if (!has) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    n_before = r_cursor;
                    n_cursor = next_b;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_free = next_free;
                    d_we   = i_ctl.update;
                    w1_en  = 1'b1;
                    if (!has || r_cursor == r_head || !is_node(r_before)) begin
                        w1_data  = r_head;
                        n_head   = r_free;
                        n_before = NIL;
                        if (!is_node(r_tail)) begin
                            n_tail = r_free;
                        end
                    end else begin
                        w1_data   = next_b;
                        n_w2_en   = 1'b1;
                        n_w2_addr = r_before[ADDR_W-1:0];
                        n_w2_data = r_free;
                    end
                    n_cursor = r_free;
                    n_count  = r_count + IDX_W'(1);
                end
            end
            CMD_ATTACH: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_free = next_free;
                    d_we   = i_ctl.update;
                    w1_en  = 1'b1;
                    if (has) begin
                        w1_data   = next_b;
                        n_w2_en   = 1'b1;
                        n_w2_addr = r_cursor[ADDR_W-1:0];
                        n_w2_data = r_free;
                        if (r_cursor == r_tail) begin
                            n_tail = r_free;
                        end
                        n_before = r_cursor;
                    end else if (!is_node(r_head)) begin
                        n_head   = r_free;
                        n_tail   = r_free;
                        n_before = NIL;
                    end else begin
                        n_w2_en   = is_node(r_tail);
                        n_w2_addr = r_tail[ADDR_W-1:0];
                        n_w2_data = r_free;
                        n_before  = r_tail;
                        n_tail    = r_free;
                    end
                    n_cursor = r_free;
                    n_count  = r_count + IDX_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!has) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    if (r_cursor == r_head || !is_node(r_before)) begin
                        if (r_head == r_tail) begin
                            n_tail = NIL;
                        end
                        n_head   = next_b;
                        n_cursor = next_b;
                        n_before = NIL;
                    end else begin
                        // unlink: before now points past the removed node
                        w1_en   = 1'b1;
                        w1_addr = r_before[ADDR_W-1:0];
                        w1_data = next_b;
                        if (r_cursor == r_tail) begin
                            n_tail = r_before;
                        end
                        n_cursor = next_b;
                    end
                    // removed node goes back to the free list
                    n_w2_en   = 1'b1;
                    n_w2_addr = r_cursor[ADDR_W-1:0];
                    n_w2_data = r_free;
                    n_free    = r_cursor;
                    if (r_count != '0) begin
                        n_count = r_count - IDX_W'(1);
                    end
                end
            end
            default: ; // read only, unused codes alike
        endcase
    end

    // one link write port: first write on update, second on finish
    always_comb begin
        if (i_ctl.finish) begin
            lw_en   = r_w2_en;
            lw_addr = r_w2_addr;
            lw_data = r_w2_data;
        end else begin
            lw_en   = i_ctl.update && w1_en;
            lw_addr = w1_addr;
            lw_data = w1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NIL;
            r_tail   <= NIL;
            r_cursor <= NIL;
            r_before <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_w2_en  <= 1'b0;
            r_err    <= ERR_OK;
        end else if (i_ctl.update) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cursor <= n_cursor;
            r_before <= n_before;
            r_free   <= n_free;
            r_count  <= n_count;
            r_w2_en  <= n_w2_en;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            r_w2_addr <= n_w2_addr;
            r_w2_data <= n_w2_data;
        end
        if (i_ctl.load_out) begin
            r_out.has_current   <= is_node(r_cursor);
            r_out.current_value <= is_node(r_cursor) ? r_rd_data : '0;
            r_out.item_count    <= 7'(r_count);
            r_out.error_code    <= r_err;
        end
    end

    assign o_word = r_out;

    `CSL_ASSERT_IMP(a_count_bound, 1'b1, r_count <= IDX_W'(CAPACITY), "count above capacity")
    `CSL_ASSERT_IMP(a_cursor_count, is_node(r_cursor), r_count != '0, "cursor set on empty list")
    `CSL_ASSERT_IMP(a_free_empty, !is_node(r_free), r_count == IDX_W'(CAPACITY), "free list lost nodes")

endmodule

>>> rtl/cursor_sequence_list_top.sv
// Top level of the cursor sequence list: controller plus datapath.
// Depends on csl_pkg, csl_ctrl and csl_dpath.
//
//  channel  | valid    | stall    | word
//  ---------+----------+----------+------------------------------
//  command  | i_valid  | o_stall  | i_word (command, data_in)
//  result   | o_valid  | i_stall  | o_word (has_current, current_value,
//           |          |          |         item_count, error_code)
//
// One command at a time: accept, update, finish, output. The single write port
// on the link memory is why update and finish are separate steps: a command may
// rewrite two links, one per cycle.
// Reset (synchronous, active low) empties the list; no clearing pass is needed,
// per-entry valid bits make unwritten links read as the initial free chain.
// A stalled result holds in the output register; the next command is taken
// as soon as that result has been loaded, while it still waits.
module cursor_sequence_list_top
    import csl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    t_ctl ctl;

    // phase sequencing and the result handshake
    csl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    // list pointers, link/data memories and the result register
    csl_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (i_word),
        .o_word  (o_word)
    );

endmodule
